// ----- hdl/wpm_pkg.sv -----
// Shared types, constants and helpers for the wildcard pattern matcher.
// Used by wpm_store, wpm_core and wildcard_pattern_matcher_top; depends on nothing.
`timescale 1ns / 1ps

package wpm_pkg;

    // Default store depths.
    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int SUBJECT_DEPTH_DEF = 256;

    // Request function codes.
    localparam logic [1:0] FUNC_PUSH_PATTERN = 2'd0;
    localparam logic [1:0] FUNC_PUSH_SUBJECT = 2'd1;
    localparam logic [1:0] FUNC_EVALUATE     = 2'd2;

    // Special pattern bytes.
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_NUL      = 8'h00;

    // Result of one match run, handed from the matcher to the top level.
    typedef struct packed {
        logic done;
        logic matched;
    } match_res_t;

    // Lower ASCII A-Z when folding is enabled.
    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold);
        logic [7:0] r;
        r = c;
        if (fold && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- hdl/wpm_store.sv -----
// Byte store with one write port and one registered read port.
// Instantiated twice by the top level for the pattern and subject strings.
`timescale 1ns / 1ps

module wpm_store #(
    parameter int DEPTH = wpm_pkg::PATTERN_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/wpm_core.sv -----
// Match sequencer: walks both stores with one shared byte comparator,
// lazy '*' handling with a single backtrack point. Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_core #(
    parameter int PATTERN_DEPTH = wpm_pkg::PATTERN_DEPTH_DEF,
    parameter int SUBJECT_DEPTH = wpm_pkg::SUBJECT_DEPTH_DEF,
    parameter int PW            = $clog2(PATTERN_DEPTH + 2),
    parameter int SW            = $clog2(SUBJECT_DEPTH + 2)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   run,
    input  logic                   fold_case,
    input  logic [PW-1:0]          plen,
    input  logic [SW-1:0]          slen,
    input  logic [7:0]             pdata,
    input  logic [7:0]             sdata,
    output logic [PW-1:0]          pidx,
    output logic [SW-1:0]          sidx,
    output logic                   active,
    output wpm_pkg::match_res_t    res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] pi_reg, pi_next;
    logic [SW-1:0] si_reg, si_next;
    logic [PW-1:0] mark_reg, mark_next;
    logic [SW-1:0] resume_reg, resume_next;
    logic          have_mark_reg, have_mark_next;

    logic [7:0]    pc;
    logic [7:0]    sc;
    logic [PW-1:0] pi_inc;
    logic [SW-1:0] si_inc;
    logic          subj_left;
    logic          char_ok;

    // Characters under the two cursors; zero past the end of a string.
    always_comb
    begin
        pc = (pi_reg < plen) ? wpm_pkg::fold_char(pdata, fold_case) : wpm_pkg::CH_NUL;
        sc = (si_reg < slen) ? wpm_pkg::fold_char(sdata, fold_case) : wpm_pkg::CH_NUL;
    end

    assign pi_inc    = pi_reg + PW'(1);
    assign si_inc    = si_reg + SW'(1);
    assign subj_left = (si_reg < slen);
    assign char_ok   = (pc != wpm_pkg::CH_NUL) &&
                       ((pc == sc) || (pc == wpm_pkg::CH_QUESTION));

    // Each match step runs through S_FETCH, which reads both bytes, then S_STEP, which decides.
    always_comb
    begin
        state_next     = state_reg;
        pi_next        = pi_reg;
        si_next        = si_reg;
        mark_next      = mark_reg;
        resume_next    = resume_reg;
        have_mark_next = have_mark_reg;
        res            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (run)
                begin
                    pi_next        = '0;
                    si_next        = '0;
                    have_mark_next = 1'b0;
                    state_next     = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                state_next = S_FETCH;
                if (!subj_left)
                begin
                    // Subject used up: only trailing stars may remain.
                    if (pc == wpm_pkg::CH_STAR)
                    begin
                        pi_next = pi_inc;
                    end
                    else
                    begin
                        res.done    = 1'b1;
                        res.matched = (pi_reg >= plen);
                        state_next  = S_IDLE;
                    end
                end
                else if (pc == wpm_pkg::CH_STAR)
                begin
                    // A star at the pattern end swallows the rest of the subject.
                    pi_next = pi_inc;
                    if (pi_inc >= plen)
                    begin
                        res.done    = 1'b1;
                        res.matched = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        mark_next      = pi_inc;
                        resume_next    = si_inc;
                        have_mark_next = 1'b1;
                    end
                end
                else if (char_ok)
                begin
                    pi_next = pi_inc;
                    si_next = si_inc;
                end
                else if (!have_mark_reg)
                begin
                    res.done    = 1'b1;
                    res.matched = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // Let the last star absorb one more subject byte.
                    pi_next     = mark_reg;
                    si_next     = resume_reg;
                    resume_next = resume_reg + SW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_mark_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_mark_reg <= have_mark_next;
        end
    end

    // Cursor registers.
    always_ff @(posedge clk)
    begin
        pi_reg     <= pi_next;
        si_reg     <= si_next;
        mark_reg   <= mark_next;
        resume_reg <= resume_next;
    end

    assign pidx   = pi_reg;
    assign sidx   = si_reg;
    assign active = (state_reg != S_IDLE);

    // A new run is only requested while the sequencer is idle.
    a_run_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        run |-> (state_reg == S_IDLE))
        else $error("match run requested while sequencer busy");

    // Every result returns the sequencer to idle.
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after a result");

    // A result only comes from the decide step.
    a_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> ($past(state_reg) == S_FETCH))
        else $error("result produced without a preceding fetch");

    // The backtrack point always lies inside the pattern.
    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_STEP) && have_mark_reg) |-> (mark_reg < plen))
        else $error("backtrack mark outside the pattern");

endmodule

// ----- hdl/wildcard_pattern_matcher_top.sv -----
// Top level of the wildcard pattern matcher: load logic, lengths, overflow,
// result registers. Depends on wpm_pkg, wpm_store and wpm_core.
//
//  Channel   Signals                          Direction  Handshake
//  request   start, func, char_code / busy    in         start & !busy
//  result    done, matched, status            out        done strobe, one cycle
//  config    cfg_valid, cfg_data / cfg_ready  in         cfg_valid & cfg_ready
//
// A pattern or subject byte load leaves busy low.
// An evaluate request runs the match sequencer step by step; each step is one
// store read and one compare in the shared comparator, and the result is
// registered after the last step. A step advances the cursors or backtracks,
// so the number of steps grows with pattern length times subject length in the
// worst case. With an overflow pending the result comes on the next cycle.
// Reset clears lengths, overflow, done and fold_case; the stores need no clearing.
// The receiver cannot stall: done is high for exactly one cycle per evaluate.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_top #(
    parameter int PATTERN_DEPTH = wpm_pkg::PATTERN_DEPTH_DEF,
    parameter int SUBJECT_DEPTH = wpm_pkg::SUBJECT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    output logic       done,
    output logic       matched,
    output logic       status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int PW  = $clog2(PATTERN_DEPTH + 2);
    localparam int SW  = $clog2(SUBJECT_DEPTH + 2);
    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int SAW = $clog2(SUBJECT_DEPTH);

    logic          fold_case_reg;
    logic [PW-1:0] plen_reg, plen_next;
    logic [SW-1:0] slen_reg, slen_next;
    logic          ovf_reg, ovf_next;
    logic          done_reg, done_next;
    logic          matched_reg, matched_next;
    logic          status_reg, status_next;

    logic          accept;
    logic          push_p, push_s, eval_req;
    logic          p_full, s_full;
    logic          run;
    logic          core_active;
    logic [PW-1:0] pidx;
    logic [SW-1:0] sidx;
    logic [7:0]    pdata, sdata;
    wpm_pkg::match_res_t core_res;

    // Request decode.
    assign accept   = start && !busy;
    assign push_p   = accept && (func == wpm_pkg::FUNC_PUSH_PATTERN) &&
                      (char_code != wpm_pkg::CH_NUL);
    assign push_s   = accept && (func == wpm_pkg::FUNC_PUSH_SUBJECT) &&
                      (char_code != wpm_pkg::CH_NUL);
    assign eval_req = accept && (func == wpm_pkg::FUNC_EVALUATE);
    assign p_full   = (plen_reg == PW'(PATTERN_DEPTH));
    assign s_full   = (slen_reg == SW'(SUBJECT_DEPTH));
    assign run      = eval_req && !ovf_reg;

    // Lengths, overflow flag and result registers.
    always_comb
    begin
        plen_next    = plen_reg;
        slen_next    = slen_reg;
        ovf_next     = ovf_reg;
        done_next    = 1'b0;
        matched_next = matched_reg;
        status_next  = status_reg;
        if (push_p)
        begin
            if (p_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                plen_next = plen_reg + PW'(1);
            end
        end
        if (push_s)
        begin
            if (s_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                slen_next = slen_reg + SW'(1);
            end
        end
        if (eval_req && ovf_reg)
        begin
            done_next    = 1'b1;
            matched_next = 1'b0;
            status_next  = 1'b1;
            plen_next    = '0;
            slen_next    = '0;
            ovf_next     = 1'b0;
        end
        if (core_res.done)
        begin
            done_next    = 1'b1;
            matched_next = core_res.matched;
            status_next  = 1'b0;
            plen_next    = '0;
            slen_next    = '0;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_case_reg <= 1'b0;
            plen_reg      <= '0;
            slen_reg      <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fold_case_reg <= cfg_data;
            end
            plen_reg <= plen_next;
            slen_reg <= slen_next;
            ovf_reg  <= ovf_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        status_reg  <= status_next;
    end

    // Pattern and subject stores.
    wpm_store #(
        .DEPTH (PATTERN_DEPTH),
        .AW    (PAW)
    ) u_pat_store (
        .clk   (clk),
        .we    (push_p && !p_full),
        .waddr (plen_reg[PAW-1:0]),
        .wdata (char_code),
        .raddr (pidx[PAW-1:0]),
        .rdata (pdata)
    );

    wpm_store #(
        .DEPTH (SUBJECT_DEPTH),
        .AW    (SAW)
    ) u_subj_store (
        .clk   (clk),
        .we    (push_s && !s_full),
        .waddr (slen_reg[SAW-1:0]),
        .wdata (char_code),
        .raddr (sidx[SAW-1:0]),
        .rdata (sdata)
    );

    // Match sequencer.
    wpm_core #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .SUBJECT_DEPTH (SUBJECT_DEPTH),
        .PW            (PW),
        .SW            (SW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .fold_case (fold_case_reg),
        .plen      (plen_reg),
        .slen      (slen_reg),
        .pdata     (pdata),
        .sdata     (sdata),
        .pidx      (pidx),
        .sidx      (sidx),
        .active    (core_active),
        .res       (core_res)
    );

    assign busy      = core_active;
    assign cfg_ready = !core_active;
    assign done      = done_reg;
    assign matched   = matched_reg;
    assign status    = status_reg;

endmodule
